/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/eett_pkg.sv */
// ----------------------------------------------------------------------------
// eett_pkg
// Shared types and codes of the expiring event timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eett_pkg;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_DEL   = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    localparam logic [2:0] STAT_ADDED  = 3'd0;
    localparam logic [2:0] STAT_FULL   = 3'd1;
    localparam logic [2:0] STAT_DELETE = 3'd2;
    localparam logic [2:0] STAT_FIRED  = 3'd3;
    localparam logic [2:0] STAT_NONE   = 3'd4;

    localparam int          REMOVED_W      = 6;
    localparam logic [31:0] WILDCARD_RESET = 32'd10001;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] event_id;
        logic [63:0] guid;
        logic [15:0] cb_id;
        logic [31:0] cb_arg;
    } entry_t;

    typedef struct packed {
        logic shift;   // move row one place toward the head
        logic keep;    // reinsert head entry at tail index
        logic load;    // write new entry at tail index
    } cell_ctrl_t;

endpackage

/* rtl/eett_if.sv */
// ----------------------------------------------------------------------------
// eett_if
// Request and response channels: valid/ready with payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eett_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] now_time;
    logic [31:0] delay;
    logic [31:0] event_id;
    logic [63:0] event_guid;
    logic [15:0] callback_id;
    logic [31:0] callback_arg;

    modport source (output valid, req_type, now_time, delay, event_id, event_guid,
                    callback_id, callback_arg, input ready);
    modport sink   (input valid, req_type, now_time, delay, event_id, event_guid,
                    callback_id, callback_arg, output ready);
endinterface

interface eett_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] fired_callback_id;
    logic [31:0] fired_callback_arg;
    logic [5:0]  removed_count;
    logic        last;

    modport source (output valid, status, fired_callback_id, fired_callback_arg,
                    removed_count, last, input ready);
    modport sink   (input valid, status, fired_callback_id, fired_callback_arg,
                    removed_count, last, output ready);
    modport mon    (input valid, ready, status, fired_callback_id, fired_callback_arg,
                    removed_count, last);
endinterface

/* rtl/eett_cell.sv */
// ----------------------------------------------------------------------------
// eett_cell
// One table slot: loads a new entry, the head entry or its upper neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eett_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  eett_pkg::cell_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    tgt,
    input  eett_pkg::entry_t    nxt_in,
    input  eett_pkg::entry_t    head_in,
    input  eett_pkg::entry_t    new_in,
    output eett_pkg::entry_t    entry_out
);
    import eett_pkg::*;

    entry_t entry_reg;
    logic   at_tgt;

    assign at_tgt    = (tgt == IDX_W'(IDX));
    assign entry_out = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && at_tgt)
        begin
            entry_reg <= new_in;
        end
        else if (ctrl.shift)
        begin
            if (ctrl.keep && at_tgt)
            begin
                entry_reg <= head_in;
            end
            else
            begin
                entry_reg <= nxt_in;
            end
        end
    end

endmodule

/* rtl/expiring_event_timer_table_top.sv */
// Add: the request is registered, then S_ADD registers the result once the output is free.
// Delete and check: one entry per cycle at the head cell while the row shifts, unless
// the response side stalls; the final response follows the last entry.
// One request in flight; a check emits one transaction per fired timer, or one none if none fired.
// Reset (async, active low): table empty, wildcard id 10001; slot data is not cleared.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// expiring_event_timer_table_top
// Timer table as a shifting row of cells with a head evaluator and sequencer.
// ----------------------------------------------------------------------------
module expiring_event_timer_table_top #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    eett_req_if.sink    req,
    eett_rsp_if.source  rsp,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import eett_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_SCAN} state_t;

    state_t        state_reg, state_next;
    logic [31:0]   wildcard_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [15:0]   pend_cb_id_reg, pend_cb_id_next;
    logic [31:0]   pend_cb_arg_reg, pend_cb_arg_next;

    logic [1:0]    rq_type_reg;
    logic [31:0]   rq_now_reg, rq_delay_reg, rq_eid_reg, rq_cbarg_reg;
    logic [63:0]   rq_guid_reg;
    logic [15:0]   rq_cbid_reg;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [15:0]   out_cb_id_reg, out_cb_id_next;
    logic [31:0]   out_cb_arg_reg, out_cb_arg_next;
    logic [5:0]    out_removed_reg, out_removed_next;
    logic          out_last_reg, out_last_next;

    cell_ctrl_t    ctrl;
    logic [CW-1:0] tgt;
    entry_t        cell_q [TABLE_DEPTH];
    entry_t        head;
    entry_t        new_entry;
    logic          accept, can_step, hit;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign can_step  = !out_valid_reg || rsp.ready;
    assign head      = cell_q[0];

    assign new_entry.expiry   = rq_now_reg + rq_delay_reg;
    assign new_entry.event_id = rq_eid_reg;
    assign new_entry.guid     = rq_guid_reg;
    assign new_entry.cb_id    = rq_cbid_reg;
    assign new_entry.cb_arg   = rq_cbarg_reg;

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.fired_callback_id  = out_cb_id_reg;
    assign rsp.fired_callback_arg = out_cb_arg_reg;
    assign rsp.removed_count      = out_removed_reg;
    assign rsp.last               = out_last_reg;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        entry_t nxt;
        if (g == TABLE_DEPTH - 1)
        begin : g_end
            assign nxt = cell_q[g];
        end
        else
        begin : g_mid
            assign nxt = cell_q[g+1];
        end
        eett_cell #(
            .IDX   (g),
            .IDX_W (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .tgt       (tgt),
            .nxt_in    (nxt),
            .head_in   (head),
            .new_in    (new_entry),
            .entry_out (cell_q[g])
        );
    end

    always_comb
    begin
        if (rq_type_reg == REQ_CHECK)
        begin
            hit = (head.expiry <= rq_now_reg);
        end
        else
        begin
            hit = (head.guid == rq_guid_reg) &&
                  ((rq_eid_reg == wildcard_reg) || (head.event_id == rq_eid_reg));
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rem_next         = rem_reg;
        removed_next     = removed_reg;
        pend_valid_next  = pend_valid_reg;
        pend_cb_id_next  = pend_cb_id_reg;
        pend_cb_arg_next = pend_cb_arg_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_cb_id_next   = out_cb_id_reg;
        out_cb_arg_next  = out_cb_arg_reg;
        out_removed_next = out_removed_reg;
        out_last_next    = out_last_reg;
        ctrl             = '0;
        tgt              = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        REQ_DEL, REQ_CHECK:
                        begin
                            state_next      = S_SCAN;
                            rem_next        = count_reg;
                            removed_next    = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (can_step)
                begin
                    out_valid_next   = 1'b1;
                    out_cb_id_next   = '0;
                    out_cb_arg_next  = '0;
                    out_removed_next = '0;
                    out_last_next    = 1'b1;
                    if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        out_status_next = STAT_FULL;
                    end
                    else
                    begin
                        out_status_next = STAT_ADDED;
                        ctrl.load       = 1'b1;
                        count_next      = count_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (can_step)
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next   = rem_reg - CW'(1);
                        ctrl.shift = 1'b1;
                        if (hit)
                        begin
                            count_next   = count_reg - CW'(1);
                            removed_next = removed_reg + CW'(1);
                            if (rq_type_reg == REQ_CHECK)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next   = 1'b1;
                                    out_status_next  = STAT_FIRED;
                                    out_cb_id_next   = pend_cb_id_reg;
                                    out_cb_arg_next  = pend_cb_arg_reg;
                                    out_removed_next = '0;
                                    out_last_next    = 1'b0;
                                end
                                pend_valid_next  = 1'b1;
                                pend_cb_id_next  = head.cb_id;
                                pend_cb_arg_next = head.cb_arg;
                            end
                        end
                        else
                        begin
                            ctrl.keep = 1'b1;
                            tgt       = count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        out_last_next    = 1'b1;
                        out_cb_id_next   = '0;
                        out_cb_arg_next  = '0;
                        out_removed_next = '0;
                        if (rq_type_reg == REQ_DEL)
                        begin
                            out_status_next  = STAT_DELETE;
                            out_removed_next = REMOVED_W'(removed_reg);
                        end
                        else if (pend_valid_reg)
                        begin
                            out_status_next = STAT_FIRED;
                            out_cb_id_next  = pend_cb_id_reg;
                            out_cb_arg_next = pend_cb_arg_reg;
                        end
                        else
                        begin
                            out_status_next = STAT_NONE;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wildcard_reg    <= WILDCARD_RESET;
            count_reg       <= '0;
            rem_reg         <= '0;
            removed_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            pend_cb_id_reg  <= '0;
            pend_cb_arg_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= '0;
            out_cb_id_reg   <= '0;
            out_cb_arg_reg  <= '0;
            out_removed_reg <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            rem_reg         <= rem_next;
            removed_reg     <= removed_next;
            pend_valid_reg  <= pend_valid_next;
            pend_cb_id_reg  <= pend_cb_id_next;
            pend_cb_arg_reg <= pend_cb_arg_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_cb_id_reg   <= out_cb_id_next;
            out_cb_arg_reg  <= out_cb_arg_next;
            out_removed_reg <= out_removed_next;
            out_last_reg    <= out_last_next;
            if (cfg_wr_en)
            begin
                wildcard_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rq_type_reg  <= req.req_type;
            rq_now_reg   <= req.now_time;
            rq_delay_reg <= req.delay;
            rq_eid_reg   <= req.event_id;
            rq_guid_reg  <= req.event_guid;
            rq_cbid_reg  <= req.callback_id;
            rq_cbarg_reg <= req.callback_arg;
        end
    end

endmodule

/* rtl/eett_checker.sv */
// ----------------------------------------------------------------------------
// eett_checker
// Port-level checks on the response channel of the timer table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eett_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic [2:0]  status,
    input logic [15:0] cb_id,
    input logic [31:0] cb_arg,
    input logic [5:0]  removed,
    input logic        last
);
    import eett_pkg::*;

    logic is_fired;
    logic is_delete;
    logic cb_set;

    assign is_fired  = (status == STAT_FIRED);
    assign is_delete = (status == STAT_DELETE);
    assign cb_set    = (cb_id != '0) || (cb_arg != '0);

    `ASSERT_NEXT(a_rsp_hold, valid && !ready, valid, "response dropped while stalled")
    `ASSERT_SAME(a_status_range, valid, status <= STAT_NONE, "status code out of range")
    `ASSERT_SAME(a_cb_zero, valid && !is_fired, !cb_set, "callback on non-fired transaction")
    `ASSERT_SAME(a_removed_zero, valid && !is_delete, removed == '0, "removed outside delete")
    `ASSERT_SAME(a_last_only_fired, valid && !last, is_fired, "non-final transaction not fired")

endmodule

bind expiring_event_timer_table_top eett_checker u_eett_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (rsp.valid),
    .ready   (rsp.ready),
    .status  (rsp.status),
    .cb_id   (rsp.fired_callback_id),
    .cb_arg  (rsp.fired_callback_arg),
    .removed (rsp.removed_count),
    .last    (rsp.last)
);

/* test/expiring_event_timer_table_top_test.sv */
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// expiring_event_timer_table_top_test
// Self-checking bench for the timer table. Requests are issued in random
// bursts and each accepted transaction is run through a local copy of the
// table to build the responses it must produce. Responses are taken under
// a changing backpressure pattern and compared field by field in order.
// The wildcard id is rewritten between phases while the table is idle.
// ----------------------------------------------------------------------------
module expiring_event_timer_table_top_test;
    import eett_pkg::*;

    localparam int         DEPTH      = 32;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         SETTLE     = DEPTH + 8;
    localparam int         IDLE_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
        logic [31:0] delay;
        logic [31:0] event_id;
        logic [63:0] guid;
        logic [15:0] cb_id;
        logic [31:0] cb_arg;
    } timer_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] cb_id;
        logic [31:0] cb_arg;
        logic [5:0]  removed;
        logic        last;
    } timer_rsp_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_PERIODIC
    } rdy_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    eett_req_if req_ch();
    eett_rsp_if rsp_ch();

    expiring_event_timer_table_top #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    timer_req_t request_q[$];
    timer_rsp_t result_q[$];
    int         err_cnt = 0;

    // local copy of the table
    logic [31:0] tbl_expiry   [DEPTH];
    logic [31:0] tbl_event_id [DEPTH];
    logic [63:0] tbl_guid     [DEPTH];
    logic [15:0] tbl_cb_id    [DEPTH];
    logic [31:0] tbl_cb_arg   [DEPTH];
    int          tbl_count;
    logic [31:0] wild_id;

    logic [31:0] clock_ms;
    logic [63:0] guid_pool [4];
    logic [31:0] id_pool   [4];

    timer_req_t cur_req;
    logic       drv_busy   = 1'b0;
    int         burst_left = 1;
    int         gap_left   = 0;

    rdy_mode_t  rdy_mode   = RDY_ALWAYS;
    int         mode_left  = 40;
    int         rdy_period = 4;
    int         rdy_phase  = 0;

    int         idle_cycles = 0;

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic timer_req_t mk_req(input logic [1:0] kind, input logic [31:0] now,
                                          input logic [31:0] delay, input logic [31:0] id,
                                          input logic [63:0] guid, input logic [15:0] cb_id,
                                          input logic [31:0] cb_arg);
        timer_req_t r;
        r.kind     = kind;
        r.now      = now;
        r.delay    = delay;
        r.event_id = id;
        r.guid     = guid;
        r.cb_id    = cb_id;
        r.cb_arg   = cb_arg;
        return r;
    endfunction

    function automatic timer_rsp_t mk_rsp(input logic [2:0] status, input logic [15:0] cb_id,
                                          input logic [31:0] cb_arg, input logic [5:0] removed,
                                          input logic last);
        timer_rsp_t r;
        r.status  = status;
        r.cb_id   = cb_id;
        r.cb_arg  = cb_arg;
        r.removed = removed;
        r.last    = last;
        return r;
    endfunction

    function automatic void table_move(input int dst, input int src);
        tbl_expiry[dst]   = tbl_expiry[src];
        tbl_event_id[dst] = tbl_event_id[src];
        tbl_guid[dst]     = tbl_guid[src];
        tbl_cb_id[dst]    = tbl_cb_id[src];
        tbl_cb_arg[dst]   = tbl_cb_arg[src];
    endfunction

    // Update the table copy and queue the responses this request produces.
    task automatic table_apply(input timer_req_t r);
        int         keep;
        int         removed;
        logic       hit;
        logic       have_prev;
        timer_rsp_t prev;
        keep      = 0;
        removed   = 0;
        have_prev = 1'b0;
        prev      = '0;
        case (r.kind)
            REQ_ADD:
            begin
                if (tbl_count >= DEPTH)
                begin
                    result_q = {result_q, mk_rsp(STAT_FULL, '0, '0, '0, 1'b1)};
                end
                else
                begin
                    tbl_expiry[tbl_count]   = r.now + r.delay;
                    tbl_event_id[tbl_count] = r.event_id;
                    tbl_guid[tbl_count]     = r.guid;
                    tbl_cb_id[tbl_count]    = r.cb_id;
                    tbl_cb_arg[tbl_count]   = r.cb_arg;
                    tbl_count++;
                    result_q = {result_q, mk_rsp(STAT_ADDED, '0, '0, '0, 1'b1)};
                end
            end
            REQ_DEL:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    hit = (tbl_guid[i] == r.guid) &&
                          ((r.event_id == wild_id) || (tbl_event_id[i] == r.event_id));
                    if (hit)
                    begin
                        removed++;
                    end
                    else
                    begin
                        table_move(keep, i);
                        keep++;
                    end
                end
                tbl_count = keep;
                result_q = {result_q, mk_rsp(STAT_DELETE, '0, '0, removed[5:0], 1'b1)};
            end
            REQ_CHECK:
            begin
                for (int i = 0; i < tbl_count; i++)
                begin
                    if (tbl_expiry[i] <= r.now)
                    begin
                        if (have_prev)
                        begin
                            result_q = {result_q, prev};
                        end
                        prev      = mk_rsp(STAT_FIRED, tbl_cb_id[i], tbl_cb_arg[i], '0, 1'b0);
                        have_prev = 1'b1;
                    end
                    else
                    begin
                        table_move(keep, i);
                        keep++;
                    end
                end
                tbl_count = keep;
                if (have_prev)
                begin
                    prev.last = 1'b1;
                    result_q  = {result_q, prev};
                end
                else
                begin
                    result_q = {result_q, mk_rsp(STAT_NONE, '0, '0, '0, 1'b1)};
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic match_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Wait until nothing is queued or outstanding, then let the block settle.
    task automatic wait_drained();
        while (request_q.size() != 0 || drv_busy || result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_wildcard(input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        wild_id      = value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mixed traffic on a slowly advancing time base; noise items do not count.
    task automatic gen_mix(input int n);
        timer_req_t r;
        int         made;
        int         pick;
        made = 0;
        while (made < n)
        begin
            pick     = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, 60);
            r.now    = clock_ms + $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
            begin
                r.now = $urandom;
            end
            r.delay    = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
            r.event_id = ($urandom_range(0, 4) == 0) ? wild_id
                                                     : id_pool[2'($urandom_range(0, 3))];
            r.guid     = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                                     : guid_pool[2'($urandom_range(0, 3))];
            r.cb_id    = 16'($urandom);
            r.cb_arg   = $urandom;
            if (pick < 45)
            begin
                r.kind = REQ_ADD;
            end
            else if (pick < 65)
            begin
                r.kind = REQ_DEL;
            end
            else if (pick < 95)
            begin
                r.kind = REQ_CHECK;
            end
            else
            begin
                r.kind = REQ_UNUSED;
            end
            request_q = {request_q, r};
            if (r.kind != REQ_UNUSED)
            begin
                made++;
            end
        end
    endtask

    // Clear, overfill under one owner, sweep by guid, refill, fire everything.
    task automatic gen_fill();
        request_q = {request_q, mk_req(REQ_CHECK, '1, '0, '0, '0, '0, '0)};
        for (int i = 0; i <= DEPTH; i++)
        begin
            request_q = {request_q, mk_req(REQ_ADD, $urandom, $urandom_range(0, 1000),
                                           $urandom, guid_pool[0], 16'($urandom),
                                           $urandom)};
        end
        request_q = {request_q, mk_req(REQ_DEL, $urandom, $urandom, wild_id, guid_pool[0],
                                       16'($urandom), $urandom)};
        for (int i = 0; i <= DEPTH; i++)
        begin
            request_q = {request_q, mk_req(REQ_ADD, $urandom, $urandom_range(0, 1000),
                                           $urandom, guid_pool[2'($urandom_range(1, 3))],
                                           16'($urandom), $urandom)};
        end
        request_q = {request_q, mk_req(REQ_CHECK, '1, '0, '0, '0, '0, '0)};
    endtask

    // request driver: bursts with random gaps
    always @(posedge clk)
    begin : drive
        if (!rst_n)
        begin
            drv_busy = 1'b0;
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (drv_busy && req_ch.ready)
            begin
                table_apply(cur_req);
                drv_busy = 1'b0;
            end
            if (!drv_busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (request_q.size() != 0)
                begin
                    cur_req  = request_q.pop_front();
                    drv_busy = 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            req_ch.valid        <= drv_busy;
            req_ch.req_type     <= cur_req.kind;
            req_ch.now_time     <= cur_req.now;
            req_ch.delay        <= cur_req.delay;
            req_ch.event_id     <= cur_req.event_id;
            req_ch.event_guid   <= cur_req.guid;
            req_ch.callback_id  <= cur_req.cb_id;
            req_ch.callback_arg <= cur_req.cb_arg;
        end
    end

    // response monitor with changing backpressure
    always @(posedge clk)
    begin : monitor
        timer_rsp_t want;
        logic       rdy;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("response transaction with nothing outstanding");
                    err_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    match_field("status", 64'(want.status), 64'(rsp_ch.status));
                    match_field("fired_callback_id", 64'(want.cb_id),
                                64'(rsp_ch.fired_callback_id));
                    match_field("fired_callback_arg", 64'(want.cb_arg),
                                64'(rsp_ch.fired_callback_arg));
                    match_field("removed_count", 64'(want.removed),
                                64'(rsp_ch.removed_count));
                    match_field("last", 64'(want.last), 64'(rsp_ch.last));
                end
            end
            if (mode_left > 0)
            begin
                mode_left--;
            end
            else
            begin
                rdy_mode   = rdy_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(20, 150);
                rdy_period = $urandom_range(2, 9);
            end
            rdy_phase = (rdy_phase + 1) % rdy_period;
            case (rdy_mode)
                RDY_ALWAYS:
                begin
                    rdy = 1'b1;
                end
                RDY_COIN:
                begin
                    rdy = 1'($urandom_range(0, 1));
                end
                default:
                begin
                    rdy = (rdy_phase == 0);
                end
            endcase
            rsp_ch.ready <= rdy;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin : watchdog
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.now_time     = '0;
        req_ch.delay        = '0;
        req_ch.event_id     = '0;
        req_ch.event_guid   = '0;
        req_ch.callback_id  = '0;
        req_ch.callback_arg = '0;
        rsp_ch.ready        = 1'b0;
        cur_req             = '0;
        wild_id             = WILDCARD_RESET;
        tbl_count           = 0;
        clock_ms            = 32'd1000;
        for (int i = 0; i < 4; i++)
        begin
            guid_pool[i] = {$urandom, $urandom};
            id_pool[i]   = $urandom;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, field extremes, wrap, delete forms, check edges
        request_q = {request_q, mk_req(REQ_CHECK, '0, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_DEL, '0, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_ADD, '0, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_ADD, '1, '1, '1, '1, '1, '1)};
        request_q = {request_q, mk_req(REQ_ADD, 32'd100, 32'd50, 32'd5, guid_pool[1],
                                       16'h1234, 32'h0000_00a1)};
        request_q = {request_q, mk_req(REQ_ADD, 32'd100, 32'd50, 32'd6, guid_pool[1],
                                       16'h5678, 32'h0000_00a2)};
        request_q = {request_q, mk_req(REQ_ADD, 32'd100, 32'd50, 32'd5, guid_pool[2],
                                       16'h9abc, 32'h0000_00a3)};
        request_q = {request_q, mk_req(REQ_DEL, '0, '0, 32'd5, guid_pool[1], '0, '0)};
        request_q = {request_q, mk_req(REQ_DEL, '0, '0, WILDCARD_RESET, guid_pool[1],
                                       '0, '0)};
        request_q = {request_q, mk_req(REQ_CHECK, '0, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_CHECK, 32'd149, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_CHECK, 32'd150, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_UNUSED, '1, '1, '1, '1, '1, '1)};
        request_q = {request_q, mk_req(REQ_CHECK, '1, '0, '0, '0, '0, '0)};
        request_q = {request_q, mk_req(REQ_DEL, '0, '0, '1, '1, '0, '0)};
        wait_drained();

        write_wildcard('0);
        gen_mix(10);
        wait_drained();

        write_wildcard('1);
        gen_mix(10);
        wait_drained();

        write_wildcard($urandom);
        gen_fill();
        gen_mix(6);
        wait_drained();

        write_wildcard(WILDCARD_RESET);
        gen_mix(10);
        wait_drained();

        if (err_cnt == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
